// ===== sv/hsl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Package for the HSL to RGB converter.
// Holds the item type passed from front to back, the hue-circle constants and queue sizing.
package hsl_pkg;

    localparam logic [15:0] HSL_ONE     = 16'd32768;
    localparam logic [15:0] HSL_HALF    = 16'd16384;

    localparam logic [16:0] TURN_UNITS  = 17'd98304;
    localparam logic [16:0] THIRD_UNITS = 17'd32768;
    localparam logic [16:0] SIXTH_UNITS = 17'd16384;
    localparam logic [16:0] HALFT_UNITS = 17'd49152;
    localparam logic [16:0] TWO3_UNITS  = 17'd65536;

    localparam logic [14:0] UNIT_FULL   = 15'd16384;
    localparam logic [8:0]  CHAN_MAX    = 9'd255;

    localparam int NUM_CHAN   = 3;
    localparam int CH_RED     = 0;
    localparam int CH_GREEN   = 1;
    localparam int CH_BLUE    = 2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic                        grey;
        logic [15:0]                 sat;
        logic [15:0]                 light;
        logic [NUM_CHAN-1:0][14:0]   unit;
    } t_item;

endpackage
`default_nettype wire

// ===== sv/hsl_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Front part: accepts HSL words, clamps saturation and lightness, places the three
// channels on the hue circle and reduces each to a ramp weight. Uses hsl_pkg.
module hsl_front
    import hsl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [14:0] i_hue,
    input  wire logic [15:0] i_saturation,
    input  wire logic [15:0] i_lightness,
    output logic             o_push,
    output t_item            o_item,
    input  wire logic        i_full
);

    function automatic logic [14:0] ramp_unit(input logic [16:0] pos);
        logic [16:0] fall;
        fall = TWO3_UNITS - pos;
        if (pos < SIXTH_UNITS) begin
            return pos[14:0];
        end else if (pos < HALFT_UNITS) begin
            return UNIT_FULL;
        end else if (pos < TWO3_UNITS) begin
            return fall[14:0];
        end else begin
            return 15'd0;
        end
    endfunction

    logic [15:0] w_sat;
    logic [15:0] w_light;
    logic [16:0] w_g3;
    logic [17:0] w_rsum;
    logic [17:0] w_bsum;
    logic [16:0] n_pos [NUM_CHAN];

    logic        r_f_vld;
    logic [15:0] r_f_sat;
    logic [15:0] r_f_light;
    logic [16:0] r_f_pos [NUM_CHAN];

    assign w_sat   = (i_saturation > HSL_ONE) ? HSL_ONE : i_saturation;
    assign w_light = (i_lightness  > HSL_ONE) ? HSL_ONE : i_lightness;
    assign w_g3    = {1'b0, i_hue, 1'b0} + {2'b00, i_hue};
    assign w_rsum  = {1'b0, w_g3} + {1'b0, THIRD_UNITS};
    assign w_bsum  = {1'b0, w_g3} + {1'b0, TWO3_UNITS};

    always_comb begin
        n_pos[CH_GREEN] = w_g3;
        n_pos[CH_RED]   = (w_rsum >= {1'b0, TURN_UNITS}) ?
                          17'(w_rsum - {1'b0, TURN_UNITS}) : w_rsum[16:0];
        n_pos[CH_BLUE]  = (w_bsum >= {1'b0, TURN_UNITS}) ?
                          17'(w_bsum - {1'b0, TURN_UNITS}) : w_bsum[16:0];
    end

    assign o_in_ready = !r_f_vld || !i_full;
    assign o_push     = r_f_vld && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_f_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_f_sat   <= w_sat;
            r_f_light <= w_light;
            r_f_pos   <= n_pos;
        end
    end

    always_comb begin
        o_item.grey  = (r_f_sat == 16'd0);
        o_item.sat   = r_f_sat;
        o_item.light = r_f_light;
        for (int c = 0; c < NUM_CHAN; c++) begin
            o_item.unit[c] = ramp_unit(r_f_pos[c]);
        end
    end

    a_hold_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f_vld && i_full) |=> r_f_vld)
        else $error("front word dropped while queue full");

endmodule
`default_nettype wire

// ===== sv/hsl_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Short queue between the front and back parts.
// Register-based, FIFO_DEPTH words of t_item from hsl_pkg.
module hsl_fifo
    import hsl_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_data,
    output logic       o_full,
    input  wire logic  i_pop,
    output t_item      o_data,
    output logic       o_empty
);

    t_item              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;
    logic               w_push;
    logic               w_pop;

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a push");

endmodule
`default_nettype wire

// ===== sv/hsl_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Back part: forms q and p, evaluates the hue ramp per channel, scales to 8 bits.
// Five pipeline stages and an output register; uses hsl_pkg.
module hsl_back
    import hsl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_item       i_item,
    input  wire logic        i_empty,
    output logic             o_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue
);

    logic        w_en;

    logic        r_b1_vld;
    t_item       r_b1_item;
    logic [30:0] r_b1_ls;
    logic [31:0] n_b1_ls;

    logic        r_b2_vld;
    t_item       r_b2_item;
    logic [30:0] r_b2_q;
    logic [7:0]  r_b2_gval;
    logic [31:0] n_b2_q;
    logic [23:0] w_gprod;
    logic [8:0]  w_gtop;

    logic        r_b3_vld;
    t_item       r_b3_item;
    logic [30:0] r_b3_p;
    logic [30:0] r_b3_d;
    logic [7:0]  r_b3_gval;
    logic [31:0] n_b3_p;
    logic [31:0] n_b3_d;

    logic        r_b4_vld;
    logic        r_b4_grey;
    logic [7:0]  r_b4_gval;
    logic [44:0] r_b4_base;
    logic [44:0] r_b4_m [NUM_CHAN];
    logic [45:0] n_b4_m [NUM_CHAN];

    logic        r_b5_vld;
    logic        r_b5_grey;
    logic [7:0]  r_b5_gval;
    logic [44:0] r_b5_v [NUM_CHAN];

    logic        r_o_vld;
    logic        r_o_grey;
    logic [7:0]  r_o_chan [NUM_CHAN];
    logic [7:0]  n_o_chan [NUM_CHAN];
    logic [52:0] w_scaled [NUM_CHAN];

    assign w_en  = !r_o_vld || i_out_ready;
    assign o_pop = w_en;

    assign n_b1_ls = i_item.light * i_item.sat;

    assign n_b2_q  = (r_b1_item.light < HSL_HALF) ?
                     ({1'b0, r_b1_item.light, 15'd0} + {1'b0, r_b1_ls}) :
                     ({(17'({1'b0, r_b1_item.light}) + 17'({1'b0, r_b1_item.sat})), 15'd0}
                      - {1'b0, r_b1_ls});
    assign w_gprod = {r_b1_item.light, 8'd0} - {8'd0, r_b1_item.light};
    assign w_gtop  = w_gprod[23:15];

    assign n_b3_p  = {r_b2_item.light, 16'd0} - {1'b0, r_b2_q};
    assign n_b3_d  = {r_b2_q, 1'b0} - {r_b2_item.light, 16'd0};

    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            n_b4_m[c]   = r_b3_d * r_b3_item.unit[c];
            w_scaled[c] = {r_b5_v[c], 8'd0} - {8'd0, r_b5_v[c]};
            n_o_chan[c] = r_b5_grey ? r_b5_gval :
                          ((w_scaled[c][52:44] > CHAN_MAX) ? CHAN_MAX[7:0]
                                                           : w_scaled[c][51:44]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld <= 1'b0;
            r_b2_vld <= 1'b0;
            r_b3_vld <= 1'b0;
            r_b4_vld <= 1'b0;
            r_b5_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else if (w_en) begin
            r_b1_vld <= !i_empty;
            r_b2_vld <= r_b1_vld;
            r_b3_vld <= r_b2_vld;
            r_b4_vld <= r_b3_vld;
            r_b5_vld <= r_b4_vld;
            r_o_vld  <= r_b5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b1_item <= i_item;
            r_b1_ls   <= n_b1_ls[30:0];

            r_b2_item <= r_b1_item;
            r_b2_q    <= n_b2_q[30:0];
            r_b2_gval <= (w_gtop > CHAN_MAX) ? CHAN_MAX[7:0] : w_gtop[7:0];

            r_b3_item <= r_b2_item;
            r_b3_p    <= n_b3_p[30:0];
            r_b3_d    <= n_b3_d[30:0];
            r_b3_gval <= r_b2_gval;

            r_b4_grey <= r_b3_item.grey;
            r_b4_gval <= r_b3_gval;
            r_b4_base <= {r_b3_p, 14'd0};
            for (int c = 0; c < NUM_CHAN; c++) begin
                r_b4_m[c] <= n_b4_m[c][44:0];
            end

            r_b5_grey <= r_b4_grey;
            r_b5_gval <= r_b4_gval;
            for (int c = 0; c < NUM_CHAN; c++) begin
                r_b5_v[c] <= r_b4_base + r_b4_m[c];
            end

            r_o_grey <= r_b5_grey;
            r_o_chan <= n_o_chan;
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_red       = r_o_chan[CH_RED];
    assign o_green     = r_o_chan[CH_GREEN];
    assign o_blue      = r_o_chan[CH_BLUE];

    a_grey_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_grey) |-> (o_red == o_green && o_green == o_blue))
        else $error("grey word with unequal channels");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> (r_b5_vld == $past(r_b5_vld) && r_b1_vld == $past(r_b1_vld)))
        else $error("pipeline advanced during stall");

endmodule
`default_nettype wire

// ===== sv/hsl_to_rgb_converter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Converts an HSL word (hue Q0.15 turn, saturation and lightness Q1.15, clamped to 1.0)
// into 8-bit RGB, truncated and saturated. One word is accepted per clock and one result
// leaves per clock while the output side is ready; each word passes the front register,
// the queue and the back stages. Throughput is set by the back pipeline, which holds one
// 31x15 ramp multiplier per channel and one q/p multiplier, each in a stage of its own.
// A four-word queue separates the front from the back, so input is still accepted after
// the output stalls, until the queue is full. Uses hsl_pkg.
module hsl_to_rgb_converter
    import hsl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [14:0] i_hue,
    input  wire logic [15:0] i_saturation,
    input  wire logic [15:0] i_lightness,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue
);

    logic  w_push;
    logic  w_full;
    logic  w_pop;
    logic  w_empty;
    t_item w_front_item;
    t_item w_queue_item;

    hsl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_lightness  (i_lightness),
        .o_push       (w_push),
        .o_item       (w_front_item),
        .i_full       (w_full)
    );

    hsl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_queue_item),
        .o_empty (w_empty)
    );

    hsl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_queue_item),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue)
    );

endmodule
`default_nettype wire
